>>> sv/dbmd_pkg.sv
// shared types and constants for the depth block median downsampler
// used by dbmd_median and depth_block_median_downsample
`default_nettype none

package dbmd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TAG_W    = 7;
    localparam int CFG_W    = 8;
    localparam int BIT_W    = 4;

    // configuration register indexes
    localparam logic CFG_BLOCKS_ACROSS = 1'b0;
    localparam logic CFG_BLOCKS_DOWN   = 1'b1;

    // limit on tile rows per frame
    localparam logic [CFG_W:0] DOWN_LIMIT = 9'd128;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_BIT,
        S_HOLD
    } t_sel_state;

    // position of a tile in the frame
    typedef struct packed {
        logic [TAG_W-1:0] col;
        logic [TAG_W-1:0] row;
        logic             last;
    } t_tile_tag;

    // finished tile result
    typedef struct packed {
        logic [SAMPLE_W-1:0] depth;
        logic                empty;
        t_tile_tag           tag;
    } t_tile_result;

endpackage

`default_nettype wire

>>> sv/depth_block_median_downsample.sv
// Block median downsampler for depth images. Pixels come in raster order and
// are written to a band memory of BLOCK rows; each pixel takes one cycle,
// except the pixel that closes a tile on the last row of a band. That pixel
// starts a radix selection over the tile: one counting pass and then one pass
// per depth bit, each reading all BLOCK*BLOCK samples through the single read
// port of the band memory, so the input stalls until the selection is done
// (only the counting pass when no sample of the tile is finite), plus any wait
// while the output register is still full. The result is the sample of rank
// floor(count/2) among finite samples, or 0 with the empty flag when none are
// finite. A finished result waits in an output register while the next
// pixels are taken.
// depends on dbmd_pkg and dbmd_median
`default_nettype none

module depth_block_median_downsample
    import dbmd_pkg::*;
#(
    parameter int BLOCK             = 8,
    parameter int MAX_BLOCKS_ACROSS = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // depth_mm
    input  wire logic        s_axis_tuser,   // finite
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // tile_depth_mm, tile_col, tile_row, zero pad
    output logic             m_axis_tuser,   // tile_empty
    output logic             m_axis_tlast    // last_in_frame
);

    localparam int ROW_PIXELS = BLOCK * MAX_BLOCKS_ACROSS;
    localparam int MEM_DEPTH  = BLOCK * ROW_PIXELS;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int TCOL_W     = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;
    localparam int RR_W       = $clog2(BLOCK);
    localparam int WX_W       = $clog2(ROW_PIXELS + 1) + 1;

    logic [CFG_W-1:0]  r_across, r_down;
    logic [RR_W-1:0]   r_sub, r_row;
    logic [TCOL_W-1:0] r_tcol;
    logic [TAG_W-1:0]  r_band;

    logic [CFG_W:0]    eff_across, eff_down;
    logic [WX_W-1:0]   col, width_px;
    logic              accept, row_end, band_end, frame_end, tile_end;
    logic              busy, res_valid, res_ready;
    t_tile_tag         tag;
    t_tile_result      res;
    logic [AW-1:0]     wr_addr;

    logic              r_m_valid;
    t_tile_result      r_m;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_across <= 8'd80;
            r_down   <= 8'd45;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLOCKS_ACROSS: r_across <= i_cfg_data;
                CFG_BLOCKS_DOWN:   r_down   <= i_cfg_data;
                default:           r_down   <= r_down;
            endcase
        end
    end

    // clamp register values to the usable range
    always_comb begin
        eff_across = {1'b0, r_across};
        if (r_across == '0) eff_across = 9'd1;
        if (eff_across > 9'(MAX_BLOCKS_ACROSS)) eff_across = 9'(MAX_BLOCKS_ACROSS);
        eff_down = {1'b0, r_down};
        if (r_down == '0) eff_down = 9'd1;
        if (eff_down > DOWN_LIMIT) eff_down = DOWN_LIMIT;
    end

    // raster position decode
    assign col       = WX_W'(WX_W'(r_tcol) * WX_W'(BLOCK) + WX_W'(r_sub));
    assign width_px  = WX_W'(WX_W'(eff_across) * WX_W'(BLOCK));
    assign row_end   = (col + WX_W'(1)) >= width_px;
    assign band_end  = (r_row == RR_W'(BLOCK - 1));
    assign frame_end = (9'(r_band) + 9'd1) >= eff_down;
    assign tile_end  = band_end && (r_sub == RR_W'(BLOCK - 1));
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy;
    assign wr_addr   = AW'(AW'(r_row) * AW'(ROW_PIXELS) + AW'(col));

    assign tag = '{col: TAG_W'(r_tcol), row: r_band, last: row_end && frame_end};

    // raster counters advance on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub  <= '0;
            r_tcol <= '0;
            r_row  <= '0;
            r_band <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_sub  <= '0;
                r_tcol <= '0;
                if (band_end) begin
                    r_row  <= '0;
                    r_band <= frame_end ? '0 : r_band + TAG_W'(1);
                end else begin
                    r_row <= r_row + RR_W'(1);
                end
            end else if (r_sub == RR_W'(BLOCK - 1)) begin
                r_sub  <= '0;
                r_tcol <= r_tcol + TCOL_W'(1);
            end else begin
                r_sub <= r_sub + RR_W'(1);
            end
        end
    end

    dbmd_median #(
        .BLOCK             (BLOCK),
        .MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS)
    ) u_median (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (accept),
        .i_wr_addr   (wr_addr),
        .i_wr_data   ({s_axis_tuser, s_axis_tdata}),
        .i_start     (accept && tile_end),
        .i_tcol      (r_tcol),
        .i_tag       (tag),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register
    assign res_ready = !r_m_valid || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m.tag.row, r_m.tag.col, r_m.depth};
    assign m_axis_tuser  = r_m.empty;
    assign m_axis_tlast  = r_m.tag.last;

endmodule

`default_nettype wire

>>> sv/dbmd_median.sv
// band memory and bitwise radix selection of the tile median
// depends on dbmd_pkg
`default_nettype none

module dbmd_median
    import dbmd_pkg::*;
#(
    parameter int BLOCK             = 8,
    parameter int MAX_BLOCKS_ACROSS = 128,
    localparam int ROW_PIXELS = BLOCK * MAX_BLOCKS_ACROSS,
    localparam int MEM_DEPTH  = BLOCK * ROW_PIXELS,
    localparam int AW         = $clog2(MEM_DEPTH),
    localparam int TCOL_W     = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire logic [AW-1:0]       i_wr_addr,
    input  wire logic [SAMPLE_W:0]   i_wr_data,   // depth, finite flag on top
    input  wire logic                i_start,
    input  wire logic [TCOL_W-1:0]   i_tcol,
    input  wire t_tile_tag           i_tag,
    output logic                     o_busy,
    output logic                     o_res_valid,
    input  wire logic                i_res_ready,
    output t_tile_result             o_res
);

    localparam int TILE_N = BLOCK * BLOCK;
    localparam int CNT_W  = $clog2(TILE_N + 1);
    localparam int RR_W   = $clog2(BLOCK);

    // band memory, one write and one registered read per cycle
    logic [SAMPLE_W:0] r_mem [MEM_DEPTH];
    logic [SAMPLE_W:0] r_rd_data;
    logic [AW-1:0]     rd_addr;

    t_sel_state          r_state, n_state;
    logic [TCOL_W-1:0]   r_tcol;
    t_tile_tag           r_tag;
    logic [RR_W-1:0]     r_rr, r_cc;
    logic [CNT_W-1:0]    r_k;
    logic                r_rd_vld;
    logic [CNT_W-1:0]    r_cnt, r_n, r_rank;
    logic [SAMPLE_W-1:0] r_prefix;
    logic [BIT_W-1:0]    r_bit;
    logic [SAMPLE_W-1:0] r_res_depth;
    logic                r_res_empty;

    logic                issue, pass_done, hit;
    logic [CNT_W-1:0]    acc;
    logic [SAMPLE_W-1:0] hi_mask, d_val;
    logic                d_fin;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
    end

    // read address of the sample being scanned
    assign rd_addr = AW'(AW'(r_rr) * AW'(ROW_PIXELS) + AW'(r_tcol) * AW'(BLOCK) + AW'(r_cc));

    // qualify the returning sample for the current pass
    assign d_val   = r_rd_data[SAMPLE_W-1:0];
    assign d_fin   = r_rd_data[SAMPLE_W];
    assign hi_mask = SAMPLE_W'({SAMPLE_W{1'b1}} << (5'(r_bit) + 5'd1));
    always_comb begin
        if (r_state == S_COUNT) begin
            hit = d_fin;
        end else begin
            hit = d_fin && (((d_val ^ r_prefix) & hi_mask) == '0) && !d_val[r_bit];
        end
    end
    assign acc       = r_cnt + CNT_W'(r_rd_vld && hit);
    assign pass_done = (r_k == CNT_W'(TILE_N));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_COUNT;
            S_COUNT: begin
                if (pass_done) n_state = (acc == '0) ? S_HOLD : S_BIT;
            end
            S_BIT: begin
                if (pass_done && r_bit == '0) n_state = S_HOLD;
            end
            S_HOLD:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_busy      = (r_state != S_IDLE);
        o_res_valid = (r_state == S_HOLD);
        issue       = (r_state == S_COUNT || r_state == S_BIT) && !pass_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
        end
    end

    // scan counters and selection datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_tcol <= i_tcol;
            r_tag  <= i_tag;
            r_rr   <= '0;
            r_cc   <= '0;
            r_k    <= '0;
            r_cnt  <= '0;
        end else if (issue) begin
            r_k   <= r_k + CNT_W'(1);
            r_cnt <= acc;
            if (r_cc == RR_W'(BLOCK - 1)) begin
                r_cc <= '0;
                r_rr <= r_rr + RR_W'(1);
            end else begin
                r_cc <= r_cc + RR_W'(1);
            end
        end else if (pass_done) begin
            r_rr  <= '0;
            r_cc  <= '0;
            r_k   <= '0;
            r_cnt <= '0;
            if (r_state == S_COUNT) begin
                r_n         <= acc;
                r_rank      <= acc >> 1;
                r_prefix    <= '0;
                r_bit       <= BIT_W'(SAMPLE_W - 1);
                r_res_depth <= '0;
                r_res_empty <= (acc == '0);
            end else begin
                r_bit <= r_bit - BIT_W'(1);
                if (r_rank < acc) begin
                    r_res_depth <= r_prefix;
                end else begin
                    r_prefix[r_bit] <= 1'b1;
                    r_rank          <= r_rank - acc;
                    r_res_depth     <= r_prefix | (SAMPLE_W'(1) << r_bit);
                end
            end
        end
    end

    assign o_res = '{depth: r_res_depth, empty: r_res_empty, tag: r_tag};

    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIT) |-> (r_rank < r_n))
        else $error("rank outside the finite sample count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT || r_state == S_BIT) |-> (r_cnt <= CNT_W'(TILE_N)))
        else $error("pass count exceeds tile size");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_start)
        else $error("tile start while selection busy");

endmodule

`default_nettype wire

>>> dv/tb_depth_block_median_downsample.sv
// testbench for depth_block_median_downsample: drives whole depth frames,
// predicts every tile median and checks each output transfer in order
// depends on dbmd_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_depth_block_median_downsample
    import dbmd_pkg::*;
();

    localparam int BLK       = 8;
    localparam int ROW_PX    = BLK * 128;
    localparam int SETTLE    = 17 * (BLK * BLK + 1) + 100;
    localparam int CYC_LIMIT = 6000000;
    localparam int HOLD_LEN  = 4000;

    // directed tile patterns
    typedef enum int {
        PAT_ALL_NAN,
        PAT_ALL_MAX,
        PAT_ALL_ZERO,
        PAT_ONE_FINITE,
        PAT_TWO_FINITE,
        PAT_RAMP,
        PAT_DOWN_RAMP,
        PAT_ALT_FINITE,
        PAT_DUPS,
        PAT_RANDOM
    } t_pattern;

    typedef struct {
        t_pattern     pat;
        bit           typed;
        t_tile_result exp;
    } t_tile_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state
    logic [16:0]  band_mem [0:BLK*ROW_PX-1];
    int unsigned  px_col, px_row, band_no;
    logic [7:0]   across_reg, down_reg;

    t_tile_result tile_q[$];
    t_tile_row    tiles[$];
    int           err_cnt = 0;
    int           tx_pct = 0, rx_pct = 0;
    int           hold_req = 0, hold_done = 0, hold_cnt = 0;
    int unsigned  cyc = 0;
    int           items = 0, tiles_seen = 0;

    depth_block_median_downsample u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned eff_across();
        if (across_reg == 0) return 1;
        if (across_reg > 128) return 128;
        return 32'(across_reg);
    endfunction

    function automatic int unsigned eff_down();
        if (down_reg == 0) return 1;
        if (down_reg > 128) return 128;
        return 32'(down_reg);
    endfunction

    // band store update and tile median on the closing pixel of a tile
    function automatic bit median_pixel(input logic [15:0] d, input logic f,
                                        output t_tile_result res);
        int unsigned  width_px, tcol;
        bit           row_end, band_end, frame_end, hit;
        logic [15:0]  vals[$];
        width_px  = eff_across() * BLK;
        row_end   = (px_col + 1) >= width_px;
        band_end  = px_row == BLK - 1;
        frame_end = band_no + 1 >= eff_down();
        hit       = 1'b0;
        band_mem[px_row * ROW_PX + px_col] = {f, d};
        if (band_end && ((px_col + 1) % BLK) == 0) begin
            tcol = px_col / BLK;
            for (int r = 0; r < BLK; r++)
                for (int c = 0; c < BLK; c++)
                    if (band_mem[r * ROW_PX + tcol * BLK + c][16])
                        vals = {vals, band_mem[r * ROW_PX + tcol * BLK + c][15:0]};
            vals.sort();
            res.depth    = vals.size() ? vals[vals.size() / 2] : 16'd0;
            res.empty    = vals.size() == 0;
            res.tag.col  = tcol[6:0];
            res.tag.row  = band_no[6:0];
            res.tag.last = row_end && frame_end;
            hit = 1'b1;
        end
        if (row_end) begin
            px_col = 0;
            if (band_end) begin
                px_row  = 0;
                band_no = frame_end ? 0 : ((band_no + 1) & 7'h7f);
            end else begin
                px_row = px_row + 1;
            end
        end else begin
            px_col = px_col + 1;
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc);
        err_cnt++;
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_tile_result w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tile_q.size() == 0) begin
                report_mismatch("unexpected tile", m_axis_tdata[15:0], -1);
            end else begin
                w = tile_q.pop_front();
                tiles_seen++;
                if (m_axis_tdata[15:0] !== w.depth)
                    report_mismatch("tile_depth_mm", m_axis_tdata[15:0], w.depth);
                if (m_axis_tuser !== w.empty)
                    report_mismatch("tile_empty", m_axis_tuser, w.empty);
                if (m_axis_tdata[22:16] !== w.tag.col)
                    report_mismatch("tile_col", m_axis_tdata[22:16], w.tag.col);
                if (m_axis_tdata[29:23] !== w.tag.row)
                    report_mismatch("tile_row", m_axis_tdata[29:23], w.tag.row);
                if (m_axis_tlast !== w.tag.last)
                    report_mismatch("last_in_frame", m_axis_tlast, w.tag.last);
            end
        end
    end

    // receiver side: random stalls plus an on-demand long hold-off
    always @(negedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done = hold_req;
            hold_cnt  = HOLD_LEN;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_pct);
        end
    end

    // one pixel transfer; the typed result replaces the predicted one if given
    task automatic send_pixel(input logic [15:0] d, input logic f,
                              input bit typed, input t_tile_result tr);
        t_tile_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        items++;
        if (median_pixel(d, f, res))
            tile_q = {tile_q, typed ? tr : res};
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (tile_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [7:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_BLOCKS_ACROSS) across_reg = val;
        else down_reg = val;
    endtask

    task automatic set_size(input logic [7:0] a, input logic [7:0] dn);
        cfg_write(CFG_BLOCKS_ACROSS, a);
        cfg_write(CFG_BLOCKS_DOWN, dn);
    endtask

    // pixel content for a directed tile, idx is the raster index in the tile
    task automatic pattern_pixel(input t_pattern p, input int idx,
                                 output logic [15:0] d, output logic f);
        d = 16'($urandom);
        f = 1'b1;
        case (p)
            PAT_ALL_NAN:    f = 1'b0;
            PAT_ALL_MAX:    d = 16'hffff;
            PAT_ALL_ZERO:   d = 16'h0000;
            PAT_ONE_FINITE: begin f = (idx == 37); d = f ? 16'd1234 : d; end
            PAT_TWO_FINITE: begin
                f = (idx == 5) || (idx == 60);
                d = (idx == 5) ? 16'd20 : (idx == 60) ? 16'd10 : d;
            end
            PAT_RAMP:       d = 16'(idx * 1000);
            PAT_DOWN_RAMP:  d = 16'(65535 - idx * 7);
            PAT_ALT_FINITE: f = idx[0];
            PAT_DUPS:       d = 16'($urandom_range(3));
            default:        f = 1'($urandom_range(1));
        endcase
    endtask

    function automatic t_tile_result mk(input logic [15:0] d, input logic e);
        t_tile_result r;
        r.depth = d; r.empty = e; r.tag.col = '0; r.tag.row = '0; r.tag.last = 1'b1;
        return r;
    endfunction

    // random frame at the current size, content style picked per frame
    task automatic send_frame(input bit with_hold);
        int unsigned  n;
        int           style;
        logic [15:0]  d;
        logic         f;
        t_tile_result none;
        n     = eff_across() * BLK * eff_down() * BLK;
        style = $urandom_range(3);
        none  = mk(16'd0, 1'b0);
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == 0) hold_req++;
            case (style)
                0: begin d = 16'($urandom); f = $urandom_range(9) != 0; end
                1: begin d = 16'($urandom_range(7) + 16'h8000); f = 1'($urandom_range(1)); end
                2: begin d = 16'($urandom); f = $urandom_range(19) == 0; end
                default: begin d = $urandom_range(1) ? 16'hffff : 16'h0; f = 1'b1; end
            endcase
            send_pixel(d, f, 1'b0, none);
        end
    endtask

    initial begin
        logic [15:0]  d;
        logic         f;
        t_tile_row    row;
        int           frame;
        px_col = 0; px_row = 0; band_no = 0;
        across_reg = 8'd80; down_reg = 8'd45;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed tiles, one-tile frames
        tiles = '{
            '{PAT_ALL_NAN,    1'b1, mk(16'd0, 1'b1)},
            '{PAT_ALL_MAX,    1'b1, mk(16'hffff, 1'b0)},
            '{PAT_ALL_ZERO,   1'b1, mk(16'd0, 1'b0)},
            '{PAT_ONE_FINITE, 1'b1, mk(16'd1234, 1'b0)},
            '{PAT_TWO_FINITE, 1'b1, mk(16'd20, 1'b0)},
            '{PAT_RAMP,       1'b0, mk(16'd0, 1'b0)},
            '{PAT_DOWN_RAMP,  1'b0, mk(16'd0, 1'b0)},
            '{PAT_ALT_FINITE, 1'b0, mk(16'd0, 1'b0)},
            '{PAT_DUPS,       1'b0, mk(16'd0, 1'b0)},
            '{PAT_RANDOM,     1'b0, mk(16'd0, 1'b0)}
        };
        set_size(8'd1, 8'd1);
        foreach (tiles[t]) begin
            row = tiles[t];
            for (int i = 0; i < BLK * BLK; i++) begin
                pattern_pixel(row.pat, i, d, f);
                send_pixel(d, f, row.typed, row.exp);
            end
        end

        // register extremes: zero acts as one
        set_size(8'd0, 8'd0);
        send_frame(1'b0);

        // random frames, idling phases rotate per frame
        frame = 0;
        while (items < 1400 || frame < 6) begin
            case (frame % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 53; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 53; end
                default: begin tx_pct = 29; rx_pct = 29; end
            endcase
            if (frame == 3)
                set_size(8'd2, 8'd2);
            else
                set_size(8'($urandom_range(1, 2)), 8'($urandom_range(1, 2)));
            send_frame(frame == 3);
            if (frame == 5) drain();
            frame++;
        end

        drain();
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
